// ----- sv/lcfc_pkg.sv -----
// shared types, codes and crc helper for the length/crc frame checker
// no dependencies
`timescale 1ns / 1ps

package lcfc_pkg;

    localparam int LCFC_FIFO_DEPTH = 4;

    localparam logic [3:0]  HDR_LAST = 4'd11;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_CRC  = 2'd2;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       payload_valid;
        logic       frame_done;
        logic [1:0] frame_status;
    } t_result;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ----- sv/length_crc_frame_checker_top.sv -----
// Length-prefixed frame checker with CRC-32. Takes one stream byte per cycle with no
// gaps of its own: the parser handles header, byte count and the per-byte crc update
// as each byte is taken, and its results go into a DEPTH-entry queue, so a result can be
// popped in the cycle after its byte is taken. Input stalls (full) only when the queue
// is full. Header bytes give no result except the last one of a frame that ends at
// once; payload bytes are passed on before the frame status is known.
// top level, depends on lcfc_pkg, lcfc_front, lcfc_fifo
`timescale 1ns / 1ps

module length_crc_frame_checker_top #(
    parameter int DEPTH = lcfc_pkg::LCFC_FIFO_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_stream_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_payload_byte,
    output logic       o_payload_valid,
    output logic       o_frame_done,
    output logic [1:0] o_frame_status
);
    import lcfc_pkg::*;

    logic    take;
    logic    wr;
    t_result item_in;
    t_result item_out;

    assign take = push && !full;

    lcfc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (i_stream_byte),
        .o_wr    (wr),
        .o_item  (item_in)
    );

    lcfc_fifo #(
        .DEPTH (DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_item  (item_in),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_item  (item_out)
    );

    assign o_payload_byte  = item_out.payload_byte;
    assign o_payload_valid = item_out.payload_valid;
    assign o_frame_done    = item_out.frame_done;
    assign o_frame_status  = item_out.frame_status;

endmodule

// ----- sv/lcfc_front.sv -----
// front end: header parse, payload byte count and crc-32, result build
// depends on lcfc_pkg
`timescale 1ns / 1ps

module lcfc_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  logic [7:0]       i_byte,
    output logic             o_wr,
    output lcfc_pkg::t_result o_item
);
    import lcfc_pkg::*;

    logic        r_in_pay, n_in_pay;
    logic [3:0]  r_hidx, n_hidx;
    logic [31:0] r_plen, n_plen;
    logic [31:0] r_ssize, n_ssize;
    logic [31:0] r_exp, n_exp;
    logic [31:0] r_left, n_left;
    logic [31:0] r_crc, n_crc;

    logic [3:0]  idx;
    logic [4:0]  sh;
    logic [31:0] crc_upd;

    always_comb begin
        n_in_pay = r_in_pay;
        n_hidx   = r_hidx;
        n_plen   = r_plen;
        n_ssize  = r_ssize;
        n_exp    = r_exp;
        n_left   = r_left;
        n_crc    = r_crc;
        o_wr     = 1'b0;
        o_item   = '0;
        idx      = (r_hidx > HDR_LAST) ? HDR_LAST : r_hidx;
        sh       = {idx[1:0], 3'b000};
        crc_upd  = crc_byte(r_crc, i_byte);
        if (i_take) begin
            if (!r_in_pay) begin
                if (idx < 4'd4) begin
                    n_plen[sh +: 8] = i_byte;
                end else if (idx < 4'd8) begin
                    n_ssize[sh +: 8] = i_byte;
                end else begin
                    n_exp[sh +: 8] = i_byte;
                end
                if (idx < HDR_LAST) begin
                    n_hidx = idx + 4'd1;
                end else begin
                    n_hidx = 4'd0;
                    n_crc  = CRC_INIT;
                    if (n_plen == 32'd0) begin
                        o_wr              = 1'b1;
                        o_item.frame_done = 1'b1;
                        if (n_ssize == 32'd0) begin
                            o_item.frame_status = ST_ZERO;
                        end else begin
                            o_item.frame_status = (n_exp == 32'd0) ? ST_OK : ST_CRC;
                        end
                    end else begin
                        n_left   = n_plen;
                        n_in_pay = 1'b1;
                    end
                end
            end else begin
                n_crc                = crc_upd;
                n_left               = r_left - 32'd1;
                o_wr                 = 1'b1;
                o_item.payload_byte  = i_byte;
                o_item.payload_valid = 1'b1;
                if (n_left == 32'd0) begin
                    o_item.frame_done   = 1'b1;
                    o_item.frame_status = ((crc_upd ^ CRC_INIT) == r_exp) ? ST_OK : ST_CRC;
                    n_in_pay            = 1'b0;
                    n_hidx              = 4'd0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_pay <= 1'b0;
            r_hidx   <= 4'd0;
            r_plen   <= 32'd0;
            r_ssize  <= 32'd0;
            r_exp    <= 32'd0;
            r_left   <= 32'd0;
            r_crc    <= CRC_INIT;
        end else begin
            r_in_pay <= n_in_pay;
            r_hidx   <= n_hidx;
            r_plen   <= n_plen;
            r_ssize  <= n_ssize;
            r_exp    <= n_exp;
            r_left   <= n_left;
            r_crc    <= n_crc;
        end
    end

endmodule

// ----- sv/lcfc_fifo.sv -----
// back end: short result queue between the parser and the consumer
// depends on lcfc_pkg
`timescale 1ns / 1ps

module lcfc_fifo #(
    parameter int DEPTH = lcfc_pkg::LCFC_FIFO_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr,
    input  lcfc_pkg::t_result i_item,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_empty,
    output lcfc_pkg::t_result o_item
);
    import lcfc_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_result       r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;
    logic          do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd];
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_wr) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (i_wr && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_wr && do_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule
